[sv/line_substring_search_unit_defines.svh]
// Assertion macros shared by the checker of the line substring search unit.
`ifndef LINE_SUBSTRING_SEARCH_UNIT_DEFINES_SVH
`define LINE_SUBSTRING_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define LSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define LSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lss_pkg.sv]
// Types, constants and helper functions of the line substring search unit.
package lss_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_FOLD_CASE      = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MATCH_LIMIT    = 3'd4;

  // Result kinds.
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Character codes.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Packed result fields, stream data width and its zero fill.
  localparam int unsigned OUT_DW  = 88;
  localparam int unsigned OUT_PAD = 7;

  typedef struct packed {
    logic        kind;
    logic [31:0] line_number;
    logic [15:0] column;
    logic [31:0] match_count;
    logic        limit_reached;
  } result_t;

  // Folds an ASCII upper case letter to lower case when enabled.
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] res;
    res = c;
    if (en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      res = c + CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

[sv/line_substring_search_unit.sv]
// Top level of the line substring search unit: window compare and result queue.
// Throughput: one byte per cycle unless the output queue is full and stalled; the
// input register, one compare stage and a two-entry output queue set this, so with
// the output stalled two results wait in the queue and a third item waits in the
// input register before in_tready falls.
// Reset: rst_n is synchronous and active low; it clears the search state, the
// queue and the registers (pattern_length to one, all others to zero).
module line_substring_search_unit #(
  parameter int unsigned PATTERN_MAX  = 16,
  parameter int unsigned LINE_LEN_MAX = 65535
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input stream.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic                         in_tlast,   // end_of_stream
  // Result stream.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [31:0] line_number, [47:32] column, [79:48] match_count,
  // [80] limit_reached, [87:81] zero
  output logic [lss_pkg::OUT_DW-1:0]   out_tdata,
  output logic                         out_tuser,  // [0] report_kind
  // Configuration write port.
  input  logic                         cfg_wr_en,
  input  logic [lss_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [63:0]                  cfg_wdata
);

  localparam int unsigned AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned LPW = $clog2(LINE_LEN_MAX + 1);
  localparam int unsigned SW  = LPW + 1;
  localparam logic [LPW-1:0] POS_MAX = LPW'(LINE_LEN_MAX);
  localparam logic [4:0]     LEN_MAX = 5'(PATTERN_MAX);

  // Configuration registers.
  logic [63:0] pattern_low_r;
  logic [63:0] pattern_high_r;
  logic [4:0]  pattern_length_r;
  logic        fold_case_r;
  logic [31:0] match_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= 5'd1;
      fold_case_r      <= 1'b0;
      match_limit_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        lss_pkg::CFG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        lss_pkg::CFG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        lss_pkg::CFG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[4:0];
        lss_pkg::CFG_FOLD_CASE:      fold_case_r      <= cfg_wdata[0];
        lss_pkg::CFG_MATCH_LIMIT:    match_limit_r    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;
  logic       proc;
  logic       pop;

  // Output queue of two entries.
  lss_pkg::result_t q_mem_r [2];
  logic             q_wp_r;
  logic             q_rp_r;
  logic [1:0]       q_cnt_r;

  assign pop       = out_tvalid && out_tready;
  assign proc      = in_vld_r && ((q_cnt_r != 2'd2) || pop);
  assign in_tready = !in_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  // Search state. The window needs no reset: only bytes of the current line
  // are ever compared, since a match needs at least the pattern's length of them.
  logic [7:0]     win_r [PATTERN_MAX];
  logic [7:0]     win_nxt [PATTERN_MAX];
  logic [LPW-1:0] pos_r, pos_nxt;
  logic [31:0]    line_r, line_nxt;
  logic [31:0]    found_r, found_nxt;
  logic           stopped_r, stopped_nxt;

  logic             res_vld;
  lss_pkg::result_t res;

  // Window compare and state update for the item in the input register.
  always_comb begin
    logic [4:0]       len;
    logic [SW-1:0]    pos_p1;
    logic [SW-1:0]    col_w;
    logic [127:0]     pat;
    logic [4:0]       idx;
    logic             hit;

    win_nxt     = win_r;
    pos_nxt     = pos_r;
    line_nxt    = line_r;
    found_nxt   = found_r;
    stopped_nxt = stopped_r;
    res_vld     = 1'b0;
    res         = '0;

    len    = (pattern_length_r > LEN_MAX) ? LEN_MAX : pattern_length_r;
    pos_p1 = {1'b0, pos_r} + SW'(1);
    pat    = {pattern_high_r, pattern_low_r};

    // Shifted window with the new byte in entry 0.
    win_nxt[0] = in_byte_r;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_nxt[j] = win_r[j-1];
    end

    hit = (len != 5'd0) && (pos_p1 >= SW'(len));
    for (int i = 0; i < PATTERN_MAX; i++) begin
      idx = len - 5'd1 - 5'(i);
      if ((5'(i) < len) &&
          (lss_pkg::fold_char(pat[8*i +: 8], fold_case_r) !=
           lss_pkg::fold_char(win_nxt[idx[AW-1:0]], fold_case_r))) begin
        hit = 1'b0;
      end
    end

    // Column of the match start, pinned once the line position saturates.
    if (pos_r >= POS_MAX) begin
      col_w = SW'(POS_MAX);
    end else begin
      col_w = pos_p1 - SW'(len);
    end

    if (in_eos_r) begin
      // Summary, then back to the reset state.
      res_vld           = 1'b1;
      res.kind          = lss_pkg::KIND_SUMMARY;
      res.line_number   = line_r;
      res.column        = '0;
      res.match_count   = found_r;
      res.limit_reached = stopped_r;
      win_nxt           = win_r;
      pos_nxt           = '0;
      line_nxt          = 32'd1;
      found_nxt         = '0;
      stopped_nxt       = 1'b0;
    end else if (stopped_r) begin
      win_nxt = win_r;
    end else if (in_byte_r == lss_pkg::CHAR_NEWLINE) begin
      win_nxt = win_r;
      pos_nxt = '0;
      if (line_r != '1) begin
        line_nxt = line_r + 32'd1;
      end
    end else begin
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_p1[LPW-1:0];
      end
      if (hit) begin
        if (found_r != '1) begin
          found_nxt = found_r + 32'd1;
        end
        stopped_nxt       = stopped_r ||
                            ((match_limit_r != '0) && (found_nxt >= match_limit_r));
        res_vld           = 1'b1;
        res.kind          = lss_pkg::KIND_MATCH;
        res.line_number   = line_r;
        res.column        = 16'(col_w[LPW-1:0]);
        res.match_count   = found_nxt;
        res.limit_reached = stopped_nxt;
      end
    end
  end

  // State registers advance when the input item is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      line_r    <= 32'd1;
      found_r   <= '0;
      stopped_r <= 1'b0;
    end else if (proc) begin
      pos_r     <= pos_nxt;
      line_r    <= line_nxt;
      found_r   <= found_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      win_r <= win_nxt;
    end
  end

  // Output queue control.
  logic push;
  assign push = proc && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_wp_r <= !q_wp_r;
      end
      if (pop) begin
        q_rp_r <= !q_rp_r;
      end
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= res;
    end
  end

  // Result stream from the queue head.
  lss_pkg::result_t head;
  assign head       = q_mem_r[q_rp_r];
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tuser  = head.kind;
  assign out_tdata  = {{lss_pkg::OUT_PAD{1'b0}}, head.limit_reached, head.match_count,
                       head.column, head.line_number};

endmodule

[sv/lss_checker.sv]
// Port checker of the line substring search unit and its bind statement.
`include "line_substring_search_unit_defines.svh"

module lss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [lss_pkg::OUT_DW-1:0] out_tdata,
  input logic                       out_tuser
);

  // A stalled result transfer keeps its contents.
  `LSS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Line numbers count from one and saturate, so they are never zero.
  `LSS_ASSERT_IMP(a_line_nonzero, out_tvalid, out_tdata[31:0] != 32'd0, "line number is zero")

  // A summary always carries column zero.
  `LSS_ASSERT_IMP(a_summary_col, out_tvalid && (out_tuser == lss_pkg::KIND_SUMMARY), out_tdata[47:32] == 16'd0, "summary column is not zero")

  // A match report counts itself, so its count is at least one.
  `LSS_ASSERT_IMP(a_match_count, out_tvalid && (out_tuser == lss_pkg::KIND_MATCH), out_tdata[79:48] != 32'd0, "match report with zero count")

endmodule

bind line_substring_search_unit lss_checker u_lss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/sv/tb_line_substring_search_unit.sv]
// Self-checking testbench of the line substring search unit, with its own search predictor.
`timescale 1ns / 1ps

module tb_line_substring_search_unit;

  localparam int unsigned PATTERN_MAX   = 16;
  localparam int unsigned LINE_LEN_MAX  = 65535;
  localparam int unsigned LONG_LINE     = 300;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 112;
  localparam int unsigned QUIET_PHASE   = 3;
  localparam int unsigned IDLE_PERCENT  = 12;
  localparam longint unsigned TIMEOUT_NS = 200000;
  localparam logic [7:0] LOWER_A = lss_pkg::CHAR_UPPER_A + lss_pkg::CASE_OFFSET;
  localparam logic [7:0] LOWER_Z = lss_pkg::CHAR_UPPER_Z + lss_pkg::CASE_OFFSET;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [7:0]                 in_tdata;
  logic                       in_tlast;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [lss_pkg::OUT_DW-1:0] out_tdata;
  logic                       out_tuser;
  logic                       cfg_wr_en;
  logic [lss_pkg::CFG_AW-1:0] cfg_addr;
  logic [63:0]                cfg_wdata;

  // Mirror of the configuration registers.
  logic [63:0]  reg_pat_lo;
  logic [63:0]  reg_pat_hi;
  logic [4:0]   reg_len;
  logic         reg_fold;
  logic [31:0]  reg_limit;

  // Predicted search state.
  logic [7:0]   srch_window [PATTERN_MAX];
  int unsigned  srch_pos;
  logic [31:0]  srch_line;
  logic [31:0]  srch_found;
  logic         srch_stopped;

  lss_pkg::result_t pending_reports [$];
  lss_pkg::result_t head_report;
  int unsigned  items_sent;
  int unsigned  reports_seen;
  int unsigned  fail_count;

  // Idle and hold-off controls shared by the stimulus and the receiver.
  logic         tx_idle_on;
  logic         rx_idle_on;
  logic         hold_req;
  int unsigned  hold_left;

  line_substring_search_unit #(
    .PATTERN_MAX  (PATTERN_MAX),
    .LINE_LEN_MAX (LINE_LEN_MAX)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still outstanding.", pending_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Case folding as the search applies it to both pattern and text.
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (reg_fold && (c >= lss_pkg::CHAR_UPPER_A) && (c <= lss_pkg::CHAR_UPPER_Z)) begin
      return c + lss_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  // One of the letters that random text and patterns are mostly made of.
  function automatic logic [7:0] pick_letter();
    case ($urandom_range(3))
      0: return lss_pkg::CHAR_UPPER_A;
      1: return lss_pkg::CHAR_UPPER_A + 8'd1;
      2: return LOWER_A;
      default: return LOWER_A + 8'd1;
    endcase
  endfunction

  function automatic logic [127:0] text_to_pattern(input string s);
    logic [127:0] p;
    int i;
    p = '0;
    for (i = 0; i < s.len(); i++) begin
      p[i*8 +: 8] = s[i];
    end
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic clear_search();
    int i;
    for (i = 0; i < PATTERN_MAX; i++) begin
      srch_window[i] = 8'd0;
    end
    srch_pos     = 0;
    srch_line    = 32'd1;
    srch_found   = 32'd0;
    srch_stopped = 1'b0;
  endtask

  // Predicts the result, if any, of one accepted input transfer.
  task automatic predict_search(input logic [7:0] b, input logic eos);
    lss_pkg::result_t r;
    logic [127:0] pat;
    int unsigned  len;
    int           i;
    logic         hit;
    logic [15:0]  col;
    if (eos) begin
      r.kind          = lss_pkg::KIND_SUMMARY;
      r.line_number   = srch_line;
      r.column        = 16'd0;
      r.match_count   = srch_found;
      r.limit_reached = srch_stopped;
      pending_reports.insert(pending_reports.size(), r);
      clear_search();
      return;
    end
    // Once the limit is reached everything but end of stream is ignored.
    if (srch_stopped) return;
    if (b == lss_pkg::CHAR_NEWLINE) begin
      for (i = 0; i < PATTERN_MAX; i++) begin
        srch_window[i] = 8'd0;
      end
      srch_pos = 0;
      if (srch_line != 32'hFFFF_FFFF) srch_line++;
      return;
    end
    for (i = PATTERN_MAX - 1; i > 0; i--) begin
      srch_window[i] = srch_window[i-1];
    end
    srch_window[0] = b;
    // Compare the newest bytes of the line with the pattern.
    pat = {reg_pat_hi, reg_pat_lo};
    len = (reg_len > PATTERN_MAX) ? PATTERN_MAX : reg_len;
    hit = (len != 0) && (srch_pos + 1 >= len);
    for (i = 0; i < len; i++) begin
      if (fold_byte(pat[i*8 +: 8]) != fold_byte(srch_window[len-1-i])) hit = 1'b0;
    end
    if (srch_pos >= LINE_LEN_MAX) col = 16'(LINE_LEN_MAX);
    else col = hit ? 16'(srch_pos + 1 - len) : 16'd0;
    if (srch_pos < LINE_LEN_MAX) srch_pos++;
    if (!hit) return;
    if (srch_found != 32'hFFFF_FFFF) srch_found++;
    if ((reg_limit != 32'd0) && (srch_found >= reg_limit)) srch_stopped = 1'b1;
    r.kind          = lss_pkg::KIND_MATCH;
    r.line_number   = srch_line;
    r.column        = col;
    r.match_count   = srch_found;
    r.limit_reached = srch_stopped;
    pending_reports.insert(pending_reports.size(), r);
  endtask

  // Offers one item and returns once it has been transferred.
  task automatic send_item(input logic [7:0] b, input logic eos);
    @(negedge clk);
    while (tx_idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    items_sent++;
    predict_search(b, eos);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
    end
  endtask

  // Stops offering and waits until every predicted result has been transferred.
  task automatic wait_for_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [lss_pkg::CFG_AW-1:0] addr,
                                input logic [63:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      lss_pkg::CFG_PATTERN_LOW:    reg_pat_lo = value;
      lss_pkg::CFG_PATTERN_HIGH:   reg_pat_hi = value;
      lss_pkg::CFG_PATTERN_LENGTH: reg_len    = value[4:0];
      lss_pkg::CFG_FOLD_CASE:      reg_fold   = value[0];
      lss_pkg::CFG_MATCH_LIMIT:    reg_limit  = value[31:0];
      default: ;
    endcase
  endtask

  // Drains the block, then writes every register.
  task automatic set_search(input logic [127:0] pat, input logic [63:0] len_word,
                            input logic [63:0] fold_word, input logic [63:0] limit_word);
    wait_for_reports();
    write_register(lss_pkg::CFG_PATTERN_LOW, pat[63:0]);
    write_register(lss_pkg::CFG_PATTERN_HIGH, pat[127:64]);
    write_register(lss_pkg::CFG_PATTERN_LENGTH, len_word);
    write_register(lss_pkg::CFG_FOLD_CASE, fold_word);
    write_register(lss_pkg::CFG_MATCH_LIMIT, limit_word);
  endtask

  // Register values after reset: a one-byte pattern of zero, extremes of the byte.
  task automatic test_reset_defaults();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(lss_pkg::CHAR_NEWLINE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // Overlapping matches, folding of both pattern and text, and a short line.
  task automatic test_fold_and_overlap();
    set_search(text_to_pattern("aA"), 64'd2, 64'd1, 64'd0);
    send_text("Aaa\nA");
    send_item(8'h00, 1'b1);
  endtask

  // A zero pattern length never matches.
  task automatic test_zero_length();
    set_search(128'd0, 64'd0, 64'd0, 64'd0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // Reporting stops at the limit; a new limit does not resume it, end of stream does.
  task automatic test_match_limit();
    set_search(text_to_pattern("z"), 64'd1, 64'd0, 64'd2);
    send_text("zzz\nz");
    wait_for_reports();
    write_register(lss_pkg::CFG_MATCH_LIMIT, 64'd0);
    send_text("z");
    send_item(8'hFF, 1'b1);
    send_text("z");
    send_item(8'h00, 1'b1);
  endtask

  // A long line, with matches at its start and at columns beyond one byte's range.
  task automatic test_long_line();
    int unsigned k;
    logic [7:0]  hit_char;
    logic [7:0]  fill_char;
    hit_char  = "a";
    fill_char = "x";
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_search(text_to_pattern("a"), 64'd1, 64'd0, 64'd0);
    for (k = 0; k < LONG_LINE; k++) begin
      send_item((k == 0 || k >= LONG_LINE - 3) ? hit_char : fill_char, 1'b0);
    end
    send_text("\na");
    send_item(8'h00, 1'b1);
    wait_for_reports();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // The receiver holds off while every byte matches, so the block must stall its input.
  task automatic test_backpressure();
    int k;
    set_search(text_to_pattern("k"), 64'd1, 64'd0, 64'd0);
    tx_idle_on = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    for (k = 0; k < 60; k++) begin
      send_item("k", 1'b0);
    end
    send_item(8'($urandom_range(255)), 1'b1);
    wait_for_reports();
    tx_idle_on = 1'b1;
  endtask

  // Random settings, each followed by text built mostly from pattern copies and letters.
  task automatic test_random_phases();
    logic [127:0] pat;
    logic [63:0]  len_word;
    logic [63:0]  fold_word;
    logic [63:0]  limit_word;
    logic [7:0]   b;
    int unsigned  phase;
    int unsigned  len;
    int unsigned  use_len;
    int unsigned  sel;
    int unsigned  n;
    int unsigned  k;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      sel = $urandom_range(99);
      if (sel < 5) len = 0;
      else if (sel < 45) len = $urandom_range(4, 1);
      else if (sel < 75) len = $urandom_range(15, 5);
      else if (sel < 90) len = PATTERN_MAX;
      else len = $urandom_range(31, 17);
      for (k = 0; k < PATTERN_MAX; k++) begin
        pat[k*8 +: 8] = ($urandom_range(99) < 85) ? pick_letter() : 8'($urandom_range(255));
      end
      // Upper bits of the narrow registers carry junk half of the time.
      len_word   = {$urandom, $urandom};
      fold_word  = {$urandom, $urandom};
      limit_word = {$urandom, $urandom};
      if ($urandom_range(1)) begin
        len_word[63:5]   = '0;
        fold_word[63:1]  = '0;
        limit_word[63:32] = '0;
      end
      len_word[4:0] = len[4:0];
      sel = $urandom_range(99);
      if (sel < 65) limit_word[31:0] = 32'd0;
      else if (sel < 82) limit_word[31:0] = $urandom_range(8, 1);
      else if (sel < 94) limit_word[31:0] = $urandom_range(40, 9);
      else limit_word[31:0] = 32'hFFFF_FFFF;
      tx_idle_on = (phase != QUIET_PHASE);
      rx_idle_on = (phase != QUIET_PHASE);
      set_search(pat, len_word, fold_word, limit_word);
      use_len = (len > PATTERN_MAX) ? PATTERN_MAX : len;
      // Each phase sends at least PHASE_ITEMS transfers, counted from its start.
      n = items_sent;
      while ((items_sent - n) < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        // While stopped, bytes are ignored, so end the stream sooner.
        if (srch_stopped && ($urandom_range(99) < 20)) sel = 99;
        if ((sel < 25) && (use_len != 0)) begin
          for (k = 0; k < use_len; k++) begin
            b = pat[k*8 +: 8];
            if (reg_fold && $urandom_range(1)) begin
              if ((b >= lss_pkg::CHAR_UPPER_A) && (b <= lss_pkg::CHAR_UPPER_Z)) begin
                b = b + lss_pkg::CASE_OFFSET;
              end else if ((b >= LOWER_A) && (b <= LOWER_Z)) begin
                b = b - lss_pkg::CASE_OFFSET;
              end
            end
            send_item(b, 1'b0);
          end
        end else if (sel < 75) begin
          send_item(pick_letter(), 1'b0);
        end else if (sel < 86) begin
          send_item(lss_pkg::CHAR_NEWLINE, 1'b0);
        end else if (sel < 98) begin
          send_item(8'($urandom_range(255)), 1'b0);
        end else begin
          send_item(8'($urandom_range(255)), 1'b1);
        end
      end
      send_item(8'($urandom_range(255)), 1'b1);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver: random idling, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= !(rx_idle_on && ($urandom_range(99) < IDLE_PERCENT));
    end
  end

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && (out_tvalid === 1'b1) && (out_tready === 1'b1)) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("result with none expected: tdata=%h tuser=%b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        head_report = pending_reports.pop_front();
        check_field("report_kind", 32'(head_report.kind), 32'(out_tuser));
        check_field("line_number", head_report.line_number, out_tdata[31:0]);
        check_field("column", 32'(head_report.column), 32'(out_tdata[47:32]));
        check_field("match_count", head_report.match_count, out_tdata[79:48]);
        check_field("limit_reached", 32'(head_report.limit_reached), 32'(out_tdata[80]));
        check_field("zero_fill", 32'd0,
                    32'(out_tdata[lss_pkg::OUT_DW-1 -: lss_pkg::OUT_PAD]));
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = lss_pkg::CFG_PATTERN_LOW;
    cfg_wdata  = 64'd0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b0;
    hold_left  = 0;
    items_sent   = 0;
    reports_seen = 0;
    fail_count   = 0;
    reg_pat_lo = 64'd0;
    reg_pat_hi = 64'd0;
    reg_len    = 5'd1;
    reg_fold   = 1'b0;
    reg_limit  = 32'd0;
    clear_search();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_fold_and_overlap();
    test_zero_length();
    test_match_limit();
    test_long_line();
    test_backpressure();
    test_random_phases();
    wait_for_reports();

    $display("Covered %0d input transfers and %0d result transfers: reset values, folding,",
             items_sent, reports_seen);
    $display("zero length, match limit, a long line, hold-off and %0d random settings.",
             RANDOM_PHASES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
